// ----- hw/rtl/wvrd_pkg.sv -----
// Shared constants, widths and interface types for the window variance rest detector.
// No dependencies; every other file of the block except wvrd_ram imports this package.
package wvrd_pkg;

  // Window geometry
  localparam int WINDOW_DEPTH = 50;
  localparam int POS_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  // Field widths
  localparam int MAG_W  = 16;
  localparam int TIME_W = 32;
  localparam int THR_W  = 30;
  localparam int HOLD_W = 32;
  localparam int VAR_W  = 30;

  // Running sums and the variance numerator / denominator
  localparam int S1_W  = MAG_W + CNT_W;
  localparam int S2_W  = 2 * MAG_W + CNT_W;
  localparam int NUM_W = S2_W + CNT_W;
  localparam int DEN_W = 2 * CNT_W;

  // Divider step counter
  localparam int DIV_STEP_W = $clog2(VAR_W);

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(167772);
  localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(3000);

  // Window stats -> divider
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } wvrd_div_req_t;

  // Rest tracker -> output register
  typedef struct packed {
    logic              resting;
    logic              started;
    logic              ended;
    logic [TIME_W-1:0] length;
  } wvrd_rest_res_t;

endpackage

// ----- hw/rtl/wvrd_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wvrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/wvrd_window.sv -----
// Sample window in RAM with running sum and sum of squares; produces the
// variance numerator n*S2 - S1^2 and denominator n*n. Uses wvrd_pkg, wvrd_ram.
module wvrd_window
  import wvrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  output logic             done,
  output wvrd_div_req_t    req
);

  typedef enum logic [2:0] {
    W_IDLE,
    W_READ,
    W_SUM,
    W_MUL,
    W_SUB
  } win_state_t;

  win_state_t       state_r;
  logic [POS_W-1:0] pos_r;
  logic             filled_r;
  logic [S1_W-1:0]  s1_r;
  logic [S2_W-1:0]  s2_r;
  logic [MAG_W-1:0] old_r;
  logic [2*MAG_W-1:0] old_sq_r;
  logic [2*MAG_W-1:0] mag_sq_r;
  logic [NUM_W-1:0] sq1_r;
  logic [NUM_W-1:0] ns2_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic             done_r;

  logic [MAG_W-1:0] rdata;
  logic             ram_re;
  logic             ram_we;
  logic [CNT_W-1:0] n_w;
  logic [NUM_W-1:0] sq1_w;
  logic [NUM_W-1:0] ns2_w;
  logic [DEN_W-1:0] den_w;

  // Read the entry to be replaced at accept, overwrite it in the cycle after
  assign ram_re = (state_r == W_IDLE) && start;
  assign ram_we = (state_r == W_READ);

  wvrd_ram #(
    .WIDTH(MAG_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos_r),
    .wdata(mag),
    .re   (ram_re),
    .raddr(pos_r),
    .rdata(rdata)
  );

  // Fill count after the update
  assign n_w   = filled_r ? CNT_W'(WINDOW_DEPTH) : CNT_W'(pos_r);
  assign sq1_w = NUM_W'(s1_r) * NUM_W'(s1_r);
  assign ns2_w = NUM_W'(n_w) * NUM_W'(s2_r);
  assign den_w = DEN_W'(n_w) * DEN_W'(n_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= W_IDLE;
      pos_r    <= '0;
      filled_r <= 1'b0;
      s1_r     <= '0;
      s2_r     <= '0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        W_IDLE: begin
          if (start) begin
            state_r <= W_READ;
          end
        end
        // Old entry only counts once the window has wrapped
        W_READ: begin
          old_r    <= filled_r ? rdata : '0;
          old_sq_r <= filled_r ? ((2*MAG_W)'(rdata) * (2*MAG_W)'(rdata)) : '0;
          mag_sq_r <= (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
          state_r  <= W_SUM;
        end
        W_SUM: begin
          s1_r <= s1_r - S1_W'(old_r) + S1_W'(mag);
          s2_r <= s2_r - S2_W'(old_sq_r) + S2_W'(mag_sq_r);
          if (pos_r == POS_W'(WINDOW_DEPTH - 1)) begin
            pos_r    <= '0;
            filled_r <= 1'b1;
          end else begin
            pos_r <= pos_r + POS_W'(1);
          end
          state_r <= W_MUL;
        end
        W_MUL: begin
          sq1_r   <= sq1_w;
          ns2_r   <= ns2_w;
          den_r   <= den_w;
          state_r <= W_SUB;
        end
        W_SUB: begin
          num_r   <= (ns2_r >= sq1_r) ? (ns2_r - sq1_r) : '0;
          done_r  <= 1'b1;
          state_r <= W_IDLE;
        end
        default: begin
          state_r <= W_IDLE;
        end
      endcase
    end
  end

  assign done    = done_r;
  assign req.num = num_r;
  assign req.den = den_r;

endmodule

// ----- hw/rtl/wvrd_div.sv -----
// Restoring divider, one quotient bit per cycle, for the window variance.
// Uses wvrd_pkg. The quotient is known to fit VAR_W bits.
module wvrd_div
  import wvrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  wvrd_div_req_t    req,
  output logic             done,
  output logic [VAR_W-1:0] quotient
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [DEN_W-1:0]      rem_r;
  logic [DEN_W-1:0]      den_r;
  logic [VAR_W-1:0]      lo_r;
  logic [VAR_W-1:0]      q_r;

  logic [DEN_W:0] trial_w;
  logic           ge_w;

  // Shift in the next dividend bit and try to subtract
  assign trial_w = {rem_r, lo_r[VAR_W-1]};
  assign ge_w    = trial_w >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          // High part is below the divisor since the quotient fits VAR_W bits
          rem_r  <= req.num[VAR_W +: DEN_W];
          lo_r   <= req.num[VAR_W-1:0];
          den_r  <= req.den;
          step_r <= DIV_STEP_W'(VAR_W - 1);
          busy_r <= 1'b1;
        end
      end else begin
        rem_r <= ge_w ? DEN_W'(trial_w - {1'b0, den_r}) : trial_w[DEN_W-1:0];
        lo_r  <= {lo_r[VAR_W-2:0], 1'b0};
        q_r   <= {q_r[VAR_W-2:0], ge_w};
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - DIV_STEP_W'(1);
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- hw/rtl/wvrd_rest.sv -----
// Rest tracker: low-variance timing, rest entry and exit with pulses.
// Uses wvrd_pkg. State commits on the update strobe.
module wvrd_rest
  import wvrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              update,
  input  logic [VAR_W-1:0]  variance,
  input  logic [TIME_W-1:0] now,
  input  logic [THR_W-1:0]  threshold,
  input  logic [HOLD_W-1:0] hold_ms,
  output wvrd_rest_res_t    res
);

  logic              rest_r;
  logic              timing_r;
  logic [TIME_W-1:0] low_start_r;
  logic [TIME_W-1:0] rest_start_r;

  logic              rest_nxt;
  logic              timing_nxt;
  logic [TIME_W-1:0] low_start_nxt;
  logic [TIME_W-1:0] rest_start_nxt;
  logic              low_w;
  logic [TIME_W-1:0] low_elapsed_w;

  assign low_w         = variance < threshold;
  assign low_elapsed_w = now - low_start_r;

  always_comb begin
    rest_nxt       = rest_r;
    timing_nxt     = timing_r;
    low_start_nxt  = low_start_r;
    rest_start_nxt = rest_start_r;
    res.started    = 1'b0;
    res.ended      = 1'b0;
    res.length     = '0;
    if (!rest_r) begin
      if (low_w) begin
        if (!timing_r) begin
          // First low sample only marks the start of the stretch
          timing_nxt    = 1'b1;
          low_start_nxt = now;
        end else if (low_elapsed_w >= hold_ms) begin
          rest_nxt       = 1'b1;
          res.started    = 1'b1;
          rest_start_nxt = low_start_r;
        end
      end else begin
        timing_nxt = 1'b0;
      end
    end else if (!low_w) begin
      res.length = now - rest_start_r;
      res.ended  = 1'b1;
      rest_nxt   = 1'b0;
      timing_nxt = 1'b0;
    end
    res.resting = rest_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r       <= 1'b0;
      timing_r     <= 1'b0;
      low_start_r  <= '0;
      rest_start_r <= '0;
    end else if (update) begin
      rest_r       <= rest_nxt;
      timing_r     <= timing_nxt;
      low_start_r  <= low_start_nxt;
      rest_start_r <= rest_start_nxt;
    end
  end

endmodule

// ----- hw/rtl/window_variance_rest_detector.sv -----
// Window variance rest detector, top level.
// Window variance path: input accept, window read/update sequence, 30-step serial divider,
// out_valid. One transaction at a time: a new input is taken only once the previous result
// is loaded into the output register. A finished result may wait in the output register.
// Reset (rst_n low, synchronous): window empty, sums and rest state cleared, config to
// defaults. Window RAM contents are not cleared; entries are used only after written.
module window_variance_rest_detector
  import wvrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MAG_W-1:0]      in_magnitude,
  input  logic [TIME_W-1:0]     in_time_ms,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VAR_W-1:0]      out_variance,
  output logic                  out_resting,
  output logic                  out_rest_started,
  output logic                  out_rest_ended,
  output logic [TIME_W-1:0]     out_rest_length_ms,
  // Configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_CALC,
    T_OUT
  } top_state_t;

  top_state_t        state_r;
  logic [MAG_W-1:0]  mag_r;
  logic [TIME_W-1:0] time_r;
  logic [VAR_W-1:0]  var_r;
  logic [THR_W-1:0]  thr_r;
  logic [HOLD_W-1:0] hold_r;
  logic              out_valid_r;
  logic [VAR_W-1:0]  out_var_r;
  wvrd_rest_res_t    out_res_r;

  logic              in_accept;
  logic              out_free;
  logic              publish;
  logic              win_done;
  wvrd_div_req_t     div_req;
  logic              div_done;
  logic [VAR_W-1:0]  div_q;
  wvrd_rest_res_t    rest_res;

  assign in_stall  = (state_r != T_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign publish   = (state_r == T_OUT) && out_free;

  wvrd_window u_window (
    .clk  (clk),
    .rst_n(rst_n),
    .start(in_accept),
    .mag  (mag_r),
    .done (win_done),
    .req  (div_req)
  );

  wvrd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (win_done),
    .req     (div_req),
    .done    (div_done),
    .quotient(div_q)
  );

  wvrd_rest u_rest (
    .clk      (clk),
    .rst_n    (rst_n),
    .update   (publish),
    .variance (var_r),
    .now      (time_r),
    .threshold(thr_r),
    .hold_ms  (hold_r),
    .res      (rest_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      hold_r <= HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESH: thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_HOLD:   hold_r <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Drained with nothing new to load
      if (out_valid_r && !out_stall && !publish) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (in_accept) begin
            mag_r   <= in_magnitude;
            time_r  <= in_time_ms;
            state_r <= T_CALC;
          end
        end
        T_CALC: begin
          if (div_done) begin
            var_r   <= div_q;
            state_r <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_free) begin
            out_var_r   <= var_r;
            out_res_r   <= rest_res;
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_variance       = out_var_r;
  assign out_resting        = out_res_r.resting;
  assign out_rest_started   = out_res_r.started;
  assign out_rest_ended     = out_res_r.ended;
  assign out_rest_length_ms = out_res_r.length;

endmodule
